// ===== rtl/mrf_pkg.sv =====
// Package for the marker record framer: command type passed from the front end
// to the back end, phase encoding and byte constants.
// No dependencies.
package mrf_pkg;

	localparam logic [7:0]  MARK_START = 8'hC8;
	localparam logic [7:0]  MARK_END   = 8'hFF;
	localparam logic [7:0]  HDR_TAG    = 8'h21;
	localparam logic [7:0]  TAIL_TAG   = 8'h02;
	localparam logic [15:0] FILL_RESET = 16'd1500;
	localparam logic [3:0]  HDR_STEPS  = 4'd8;
	localparam logic [3:0]  TAIL_STEPS = 4'd8;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [0:0] REG_FILL = 1'b0;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_SKIP1,
		PH_SKIP2,
		PH_COPY
	} phase_t;

	typedef enum logic [1:0] {
		CMD_MARK,
		CMD_DATA,
		CMD_END
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data;
		logic        hdr;
		logic [7:0]  frame_idx;
		logic [31:0] len;
		logic [2:0]  pad;
		logic        close;
	} cmd_t;

endpackage

// ===== rtl/marker_record_framer.sv =====
// Marker record framer, top level: register port, front end, queue, back end.
// Commands pass through the queue and the back end's command register to the output register.
// The output gives one byte a cycle unless out_ready stalls it. Input is taken every cycle while
// the four-entry command queue has room, so the sustained rate is set by the output port and the
// bytes each record expands to. Reset clears all phase, count and frame state and sets the fill
// threshold to 1500. Depends on mrf_pkg, mrf_front, mrf_fifo and mrf_back.
module marker_record_framer import mrf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  raw_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        frame_end,
	output logic        run_last
);

	logic [15:0] fill_q;
	logic        acc;
	logic        push;
	logic        full;
	logic        pop;
	logic        q_valid;
	cmd_t        wr_cmd;
	cmd_t        rd_cmd;

	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_FILL) ? {16'd0, fill_q} : 32'd0;
	assign in_ready = !full;
	assign acc      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= FILL_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_FILL) begin
			fill_q <= pwdata[15:0];
		end
	end

	mrf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.raw_byte (raw_byte),
		.fill     (fill_q),
		.push     (push),
		.cmd      (wr_cmd)
	);

	mrf_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_cmd   (wr_cmd),
		.full     (full),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_cmd   (rd_cmd)
	);

	mrf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (rd_cmd),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.frame_end (frame_end),
		.run_last  (run_last)
	);

endmodule

// ===== rtl/mrf_front.sv =====
// Front end of the marker record framer: hunts for markers, tracks record and
// frame counts and turns start markers and copied record bytes into commands for the back end.
// Depends on mrf_pkg.
module mrf_front import mrf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        acc,
	input  logic [7:0]  raw_byte,
	input  logic [15:0] fill,
	output logic        push,
	output cmd_t        cmd
);

	phase_t      phase_q, phase_n;
	logic [31:0] rec_len_q, rec_len_n;
	logic [15:0] frame_bytes_q, frame_bytes_n;
	logic [7:0]  frame_idx_q, frame_idx_n;
	logic        hdr_sent_q, hdr_sent_n;
	logic [31:0] len_inc;
	logic [2:0]  pad;
	logic [15:0] fb_base;
	logic [16:0] sum_mark, sum_data, sum_end;
	logic [15:0] sat_mark, sat_data, sat_end;
	logic        close;

	assign len_inc  = rec_len_q + 32'd1;
	assign pad      = 3'd0 - len_inc[2:0];
	assign fb_base  = hdr_sent_q ? frame_bytes_q : 16'd8;
	assign sum_mark = {1'b0, fb_base} + 17'd1;
	assign sum_data = {1'b0, frame_bytes_q} + 17'd1;
	assign sum_end  = {1'b0, frame_bytes_q} + 17'd9 + {14'd0, pad};
	assign sat_mark = sum_mark[16] ? 16'hFFFF : sum_mark[15:0];
	assign sat_data = sum_data[16] ? 16'hFFFF : sum_data[15:0];
	assign sat_end  = sum_end[16] ? 16'hFFFF : sum_end[15:0];
	assign close    = sat_end >= fill;

	always_comb begin
		phase_n       = phase_q;
		rec_len_n     = rec_len_q;
		frame_bytes_n = frame_bytes_q;
		frame_idx_n   = frame_idx_q;
		hdr_sent_n    = hdr_sent_q;
		push          = 1'b0;
		cmd.kind      = CMD_DATA;
		cmd.data      = raw_byte;
		cmd.hdr       = !hdr_sent_q;
		cmd.frame_idx = frame_idx_q;
		cmd.len       = len_inc;
		cmd.pad       = pad;
		cmd.close     = close;
		case (phase_q)
			PH_HUNT: begin
				if (raw_byte == MARK_START) begin
					push          = acc;
					cmd.kind      = CMD_MARK;
					frame_bytes_n = sat_mark;
					rec_len_n     = 32'd1;
					hdr_sent_n    = 1'b1;
					phase_n       = PH_SKIP1;
				end
			end
			PH_SKIP1: phase_n = PH_SKIP2;
			PH_SKIP2: phase_n = PH_COPY;
			PH_COPY: begin
				push      = acc;
				rec_len_n = len_inc;
				if (raw_byte == MARK_END) begin
					cmd.kind = CMD_END;
					phase_n  = PH_HUNT;
					if (close) begin
						hdr_sent_n    = 1'b0;
						frame_bytes_n = 16'd0;
						frame_idx_n   = frame_idx_q + 8'd1;
					end else begin
						frame_bytes_n = sat_end;
					end
				end else begin
					frame_bytes_n = sat_data;
				end
			end
			default: phase_n = PH_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			rec_len_q     <= 32'd0;
			frame_bytes_q <= 16'd0;
			frame_idx_q   <= 8'd0;
			hdr_sent_q    <= 1'b0;
		end else if (acc) begin
			phase_q       <= phase_n;
			rec_len_q     <= rec_len_n;
			frame_bytes_q <= frame_bytes_n;
			frame_idx_q   <= frame_idx_n;
			hdr_sent_q    <= hdr_sent_n;
		end
	end

endmodule

// ===== rtl/mrf_fifo.sv =====
// Short command queue between the front end and the back end of the framer.
// Depends on mrf_pkg.
module mrf_fifo import mrf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic pop,
	output logic rd_valid,
	output cmd_t rd_cmd
);

	cmd_t         mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0]   count_q;

	assign full     = count_q == (QAW+1)'(QDEPTH);
	assign rd_valid = count_q != '0;
	assign rd_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/mrf_back.sv =====
// Back end of the framer: expands each queued command into header, record,
// padding and tail bytes, one per cycle unless out_ready stalls the output,
// into a registered output stage. Depends on mrf_pkg.
module mrf_back import mrf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  cmd_t       q_cmd,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       frame_end,
	output logic       run_last
);

	cmd_t       cur_q;
	logic       cur_valid_q;
	logic [3:0] step_q;
	logic [3:0] last_step;
	logic [3:0] tail_pos;
	logic       is_last;
	logic       emit;
	logic [7:0] byte_n;
	logic       fe_n;

	assign last_step = (cur_q.kind == CMD_MARK) ? HDR_STEPS :
	                   (cur_q.kind == CMD_END) ? ({1'b0, cur_q.pad} + TAIL_STEPS) : 4'd0;
	assign is_last   = step_q == last_step;
	assign emit      = cur_valid_q && (!out_valid || out_ready);
	assign q_pop     = q_valid && (!cur_valid_q || (emit && is_last));
	assign tail_pos  = step_q - {1'b0, cur_q.pad} - 4'd1;

	always_comb begin
		byte_n = 8'd0;
		fe_n   = 1'b0;
		case (cur_q.kind)
			CMD_MARK: begin
				if (step_q == HDR_STEPS) begin
					byte_n = cur_q.data;
				end else if (step_q == 4'd0) begin
					byte_n = HDR_TAG;
				end else if (step_q == 4'd1) begin
					byte_n = cur_q.frame_idx;
				end
			end
			CMD_DATA: byte_n = cur_q.data;
			CMD_END: begin
				if (step_q == 4'd0) begin
					byte_n = cur_q.data;
				end else if (step_q > {1'b0, cur_q.pad}) begin
					case (tail_pos[2:0])
						3'd0:    byte_n = cur_q.len[7:0];
						3'd1:    byte_n = cur_q.len[15:8];
						3'd2:    byte_n = cur_q.len[23:16];
						3'd3:    byte_n = cur_q.len[31:24];
						3'd7:    byte_n = TAIL_TAG;
						default: byte_n = 8'd0;
					endcase
					fe_n = is_last && cur_q.close;
				end
			end
			default: byte_n = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_cmd;
		end
		if (emit) begin
			out_byte  <= byte_n;
			frame_end <= fe_n;
			run_last  <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			step_q      <= 4'd0;
			out_valid   <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				step_q      <= (q_cmd.kind == CMD_MARK && !q_cmd.hdr) ? HDR_STEPS : 4'd0;
			end else if (emit && is_last) begin
				cur_valid_q <= 1'b0;
			end else if (emit) begin
				step_q <= step_q + 4'd1;
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule
